// ===== rtl/core/arabic_cursive_joining_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the cursive joining block
// Concurrent checks that vanish in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef ARABIC_CURSIVE_JOINING_DEFINES_SVH
`define ARABIC_CURSIVE_JOINING_DEFINES_SVH

`ifndef SYNTHESIS

// check prop on every rising edge, skipped while reset is high
`define ACJ_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check prop on every rising edge, reset included
`define ACJ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ACJ_ASSERT(lbl, clk, rst, prop, msg)

`define ACJ_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/core/acj_pkg.sv =====
// ---------------------------------------------------------------------------
// acj_pkg
// Shared types, constants and join masks of the cursive joining block.
// ---------------------------------------------------------------------------
package acj_pkg;

   // character word: bit 0 joins right, bit 1 joins left, bit 2 skipped,
   // bits 10..3 pass-through properties
   localparam int CHAR_W    = 11;
   localparam int BIT_JR    = 0;
   localparam int BIT_JL    = 1;
   localparam int BIT_SK    = 2;
   localparam int PROPS_LSB = 3;
   localparam int PROPS_W   = 8;

   localparam int QUEUE_DEPTH = 2;

   typedef logic [CHAR_W-1:0] hold_char_type;

   localparam hold_char_type MASK_JR   = hold_char_type'(1) << BIT_JR;
   localparam hold_char_type MASK_JL   = hold_char_type'(1) << BIT_JL;
   localparam hold_char_type MASK_BOTH = MASK_JR | MASK_JL;

   // one classified item, handed from the front to the back
   typedef struct packed {
      hold_char_type chr;       // character as it enters the hold buffer
      logic          rtl;       // direction of the item
      logic          pre_rtl;   // direction of the run flushed before it
      logic          pre_flush; // flush held characters before storing chr
      logic          head_clr;  // clear following-join bit of held head
      logic          tail_join; // set both join bits on held skipped chars
      logic          ovf;       // flush cut by a full buffer
      logic          eot;       // flush everything after storing chr
   } acj_cmd_type;

   // join bit toward the preceding character
   function automatic hold_char_type prec_mask(input logic rtl);
      return rtl ? MASK_JR : MASK_JL;
   endfunction

   // join bit toward the following character
   function automatic hold_char_type foll_mask(input logic rtl);
      return rtl ? MASK_JL : MASK_JR;
   endfunction

endpackage

// ===== rtl/core/arabic_cursive_joining.sv =====
// ---------------------------------------------------------------------------
// arabic_cursive_joining
// Streaming cursive joining of characters within runs of equal direction.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one character per item with valid/ready; rsp_* returns the
//   resolved characters with valid/ready, in input order, each exactly once.
//   An item may cause no result (it is held until a later item or end of text
//   flushes it), or a burst; rsp_burst_last marks the last result of a burst.
//   The front classifies an item in the cycle it is accepted and places it
//   in a two-entry queue; the back drains held characters from its buffer.
//   The first result of a burst passes through the queue, the back's state and
//   command registers and the output register. An item that only joins the held
//   group is appended to the hold buffer; an item that flushes n held characters
//   (plus m more at end of text) sends them one at a time through the single
//   output register and the hold buffer read port, and the back takes no new item until then.
//   Reset (synchronous, active high) closes any open run and empties the
//   queue and output register; no clearing pass is needed.
//   A stalled receiver holds the output register; the back then waits and
//   the front keeps taking items until the queue is full.
// ---------------------------------------------------------------------------
module arabic_cursive_joining
   import acj_pkg::*;
#(
   parameter int SKIP_DEPTH = 16
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_rtl,
   input  logic                req_joins_right,
   input  logic                req_joins_left,
   input  logic                req_skipped,
   input  logic [PROPS_W-1:0]  req_other_props,
   input  logic                req_end_of_text,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_out_joins_right,
   output logic                rsp_out_joins_left,
   output logic                rsp_out_skipped,
   output logic [PROPS_W-1:0]  rsp_out_other_props,
   output logic                rsp_overflow,
   output logic                rsp_burst_last
);

   logic        fq_valid, fq_ready;
   acj_cmd_type fq_data;
   logic        qb_valid, qb_ready;
   acj_cmd_type qb_data;

   acj_front #(
      .SKIP_DEPTH (SKIP_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rtl         (req_rtl),
      .req_joins_right (req_joins_right),
      .req_joins_left  (req_joins_left),
      .req_skipped     (req_skipped),
      .req_other_props (req_other_props),
      .req_end_of_text (req_end_of_text),
      .cmd_valid       (fq_valid),
      .cmd_ready       (fq_ready),
      .cmd             (fq_data)
   );

   acj_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   acj_back #(
      .SKIP_DEPTH (SKIP_DEPTH)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .cmd_valid           (qb_valid),
      .cmd_ready           (qb_ready),
      .cmd                 (qb_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_joins_right (rsp_out_joins_right),
      .rsp_out_joins_left  (rsp_out_joins_left),
      .rsp_out_skipped     (rsp_out_skipped),
      .rsp_out_other_props (rsp_out_other_props),
      .rsp_overflow        (rsp_overflow),
      .rsp_burst_last      (rsp_burst_last)
   );

endmodule

// ===== rtl/core/acj_cmd_queue.sv =====
// ---------------------------------------------------------------------------
// acj_cmd_queue
// Short queue of classified items between the front and the back.
// ---------------------------------------------------------------------------
module acj_cmd_queue
   import acj_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  acj_cmd_type push_data,
   output logic        pop_valid,
   input  logic        pop_ready,
   output acj_cmd_type pop_data
);

   localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

   acj_cmd_type         entries_ff [QUEUE_DEPTH];
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]     fill_ff, fill_in;
   logic                do_push, do_pop;

   assign push_ready = (fill_ff != CNTW'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNTW'(1);
      end else if (!do_push && do_pop) begin
         fill_in = fill_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/acj_front.sv =====
// ---------------------------------------------------------------------------
// acj_front
// Takes in characters, tracks the open run and decides each join.
// ---------------------------------------------------------------------------
module acj_front
   import acj_pkg::*;
#(
   parameter int SKIP_DEPTH = 16
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_rtl,
   input  logic                req_joins_right,
   input  logic                req_joins_left,
   input  logic                req_skipped,
   input  logic [PROPS_W-1:0]  req_other_props,
   input  logic                req_end_of_text,
   output logic                cmd_valid,
   input  logic                cmd_ready,
   output acj_cmd_type         cmd
);

   localparam int HOLD_SLOTS = SKIP_DEPTH + 1;
   localparam int CW         = $clog2(HOLD_SLOTS + 1);

   logic          run_open_ff, run_open_in;
   logic          run_rtl_ff, run_rtl_in;
   logic          pending_ff, pending_in;
   logic [CW-1:0] count_ff, count_in;
   logic          accept;
   logic          dir_change;
   logic          cont;
   hold_char_type c_raw;
   hold_char_type pm, fm;

   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;
   assign accept    = req_valid & cmd_ready;

   assign c_raw      = {req_other_props, req_skipped, req_joins_left, req_joins_right};
   assign dir_change = run_open_ff && (req_rtl != run_rtl_ff);
   assign cont       = run_open_ff && !dir_change;
   assign pm         = prec_mask(run_rtl_ff);
   assign fm         = foll_mask(run_rtl_ff);

   always_comb begin
      cmd.chr       = c_raw;
      cmd.rtl       = req_rtl;
      cmd.pre_rtl   = run_rtl_ff;
      cmd.pre_flush = 1'b0;
      cmd.head_clr  = 1'b0;
      cmd.tail_join = 1'b0;
      cmd.ovf       = 1'b0;
      cmd.eot       = req_end_of_text;
      run_open_in   = 1'b1;
      run_rtl_in    = req_rtl;
      pending_in    = pending_ff;
      count_in      = count_ff;

      if (!cont) begin
         // open a new run, closing the old one on a direction change
         cmd.pre_flush = dir_change;
         cmd.head_clr  = dir_change;
         pending_in    = 1'b0;
         if (!req_skipped) begin
            cmd.chr    = c_raw & ~prec_mask(req_rtl);
            pending_in = |(cmd.chr & foll_mask(req_rtl));
         end
         count_in = CW'(1);
      end else if (req_skipped) begin
         if (count_ff == CW'(HOLD_SLOTS)) begin
            // buffer full: cut the run and restart with this item
            cmd.pre_flush = 1'b1;
            cmd.head_clr  = 1'b1;
            cmd.ovf       = 1'b1;
            pending_in    = 1'b0;
            count_in      = CW'(1);
         end else begin
            count_in = count_ff + CW'(1);
         end
      end else begin
         cmd.pre_flush = 1'b1;
         cmd.head_clr  = pending_ff && !(|(c_raw & pm));
         cmd.tail_join = pending_ff && (|(c_raw & pm));
         if (!pending_ff) begin
            cmd.chr = c_raw & ~pm;
         end
         pending_in = |(cmd.chr & fm);
         count_in   = CW'(1);
      end

      if (req_end_of_text) begin
         run_open_in = 1'b0;
         pending_in  = 1'b0;
         count_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff <= 1'b0;
         run_rtl_ff  <= 1'b0;
         pending_ff  <= 1'b0;
         count_ff    <= '0;
      end else if (accept) begin
         run_open_ff <= run_open_in;
         run_rtl_ff  <= run_rtl_in;
         pending_ff  <= pending_in;
         count_ff    <= count_in;
      end
   end

endmodule

// ===== rtl/core/acj_back.sv =====
// ---------------------------------------------------------------------------
// acj_back
// Holds characters of the open run and drains them one per cycle while the output is free.
// ---------------------------------------------------------------------------
`include "arabic_cursive_joining_defines.svh"

module acj_back
   import acj_pkg::*;
#(
   parameter int SKIP_DEPTH = 16
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   output logic                cmd_ready,
   input  acj_cmd_type         cmd,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_out_joins_right,
   output logic                rsp_out_joins_left,
   output logic                rsp_out_skipped,
   output logic [PROPS_W-1:0]  rsp_out_other_props,
   output logic                rsp_overflow,
   output logic                rsp_burst_last
);

   localparam int HOLD_SLOTS = SKIP_DEPTH + 1;
   localparam int CW         = $clog2(HOLD_SLOTS + 1);
   localparam int IW         = $clog2(HOLD_SLOTS);

   typedef enum logic [1:0] {
      S_IDLE,
      S_PRE,
      S_POST
   } state_type;

   state_type     state_ff, state_in;
   acj_cmd_type   cmd_ff, cmd_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   hold_char_type rsp_char_ff, rsp_char_in;
   logic          rsp_ovf_ff, rsp_ovf_in;
   logic          rsp_last_ff, rsp_last_in;

   hold_char_type mem [HOLD_SLOTS];
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   hold_char_type mem_wdata;
   hold_char_type rd_char_ff;

   hold_char_type rd_char;
   logic          out_free;
   logic          is_last;

   assign rd_char  = rd_char_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign is_last  = (CW'(idx_ff) == (count_ff - CW'(1)));

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;
      cmd_ready    = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = count_ff[IW-1:0];
      mem_wdata    = cmd.chr;

      case (state_ff)
         S_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cmd_in = cmd;
               idx_in = '0;
               if (cmd.pre_flush) begin
                  state_in = S_PRE;
               end else begin
                  // append to the held group
                  mem_we   = 1'b1;
                  count_in = count_ff + CW'(1);
                  if (cmd.eot) begin
                     state_in = S_POST;
                  end
               end
            end
         end
         S_PRE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = rd_char;
               if (idx_ff == '0) begin
                  if (cmd_ff.head_clr) begin
                     rsp_char_in = rd_char & ~foll_mask(cmd_ff.pre_rtl);
                  end
               end else if (cmd_ff.tail_join) begin
                  rsp_char_in = rd_char | MASK_BOTH;
               end
               rsp_ovf_in  = cmd_ff.ovf;
               rsp_last_in = is_last && !cmd_ff.eot;
               idx_in      = idx_ff + IW'(1);
               if (is_last) begin
                  // old group gone: the new character becomes the head
                  mem_we    = 1'b1;
                  mem_waddr = '0;
                  mem_wdata = cmd_ff.chr;
                  count_in  = CW'(1);
                  idx_in    = '0;
                  state_in  = cmd_ff.eot ? S_POST : S_IDLE;
               end
            end
         end
         S_POST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = rd_char;
               if (idx_ff == '0) begin
                  rsp_char_in = rd_char & ~foll_mask(cmd_ff.rtl);
               end
               rsp_ovf_in  = 1'b0;
               rsp_last_in = is_last;
               idx_in      = idx_ff + IW'(1);
               if (is_last) begin
                  count_in = '0;
                  idx_in   = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      rsp_char_ff <= rsp_char_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      rsp_last_ff <= rsp_last_in;
   end

   // read the entry at the next index; forward a write to that same entry
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_we && (mem_waddr == idx_in)) begin
         rd_char_ff <= mem_wdata;
      end else begin
         rd_char_ff <= mem[idx_in];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_joins_right = rsp_char_ff[BIT_JR];
   assign rsp_out_joins_left  = rsp_char_ff[BIT_JL];
   assign rsp_out_skipped     = rsp_char_ff[BIT_SK];
   assign rsp_out_other_props = rsp_char_ff[PROPS_LSB +: PROPS_W];
   assign rsp_overflow        = rsp_ovf_ff;
   assign rsp_burst_last      = rsp_last_ff;

   `ACJ_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(HOLD_SLOTS), "held count beyond capacity")
   `ACJ_ASSERT(a_pre_nonempty, clock, reset, (state_ff == S_PRE) |-> (count_ff != '0), "flush of an empty group")
   `ACJ_ASSERT(a_post_done, clock, reset, (state_ff == S_POST && out_free && is_last) |=> (state_ff == S_IDLE && count_ff == '0), "end of text left characters held")
   `ACJ_ASSERT(a_idle_no_take, clock, reset, (state_ff != S_IDLE) |-> !cmd_ready, "item taken during a drain")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb - cursive joining block testbench
// Feeds text items with valid/ready under several idle and stall patterns,
// predicts the resolved characters in order and compares every result.
// ---------------------------------------------------------------------------
module tb
   import acj_pkg::*;
();

   localparam int SKIP_DEPTH     = 16;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int DRAIN_CYCLES   = 20;

   typedef struct packed {
      bit            rtl;
      bit            jr;
      bit            jl;
      bit            sk;
      bit [7:0]      props;
      bit            eot;
   } text_char_type;

   typedef struct packed {
      hold_char_type chr;
      bit            ovf;
      bit            burst_end;
   } joined_char_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_rtl = 1'b0;
   logic               req_joins_right = 1'b0;
   logic               req_joins_left = 1'b0;
   logic               req_skipped = 1'b0;
   logic [PROPS_W-1:0] req_other_props = '0;
   logic               req_end_of_text = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_out_joins_right;
   logic               rsp_out_joins_left;
   logic               rsp_out_skipped;
   logic [PROPS_W-1:0] rsp_out_other_props;
   logic               rsp_overflow;
   logic               rsp_burst_last;

   text_char_type   text_q[$];
   joined_char_type joined_q[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int holdoff_trig = 0;
   int holdoff_seen = 0;
   int holdoff_left = 0;
   int cycle_count = 0;
   int rsp_count = 0;
   int mismatch_count = 0;

   // joining state of the open run
   hold_char_type held [0:SKIP_DEPTH];
   int            held_n;
   bit            pend_join;
   bit            run_dir;
   bit            run_live;

   arabic_cursive_joining #(
      .SKIP_DEPTH(SKIP_DEPTH)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rtl             (req_rtl),
      .req_joins_right     (req_joins_right),
      .req_joins_left      (req_joins_left),
      .req_skipped         (req_skipped),
      .req_other_props     (req_other_props),
      .req_end_of_text     (req_end_of_text),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_joins_right (rsp_out_joins_right),
      .rsp_out_joins_left  (rsp_out_joins_left),
      .rsp_out_skipped     (rsp_out_skipped),
      .rsp_out_other_props (rsp_out_other_props),
      .rsp_overflow        (rsp_overflow),
      .rsp_burst_last      (rsp_burst_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // join bit toward the preceding character
   function automatic hold_char_type lead_bit(bit dir);
      return dir ? MASK_JR : MASK_JL;
   endfunction

   // join bit toward the following character
   function automatic hold_char_type trail_bit(bit dir);
      return dir ? MASK_JL : MASK_JR;
   endfunction

   function automatic void emit_group(bit ovf);
      joined_char_type j;
      for (int k = 0; k < held_n; k++) begin
         j.chr       = held[k];
         j.ovf       = ovf;
         j.burst_end = 1'b0;
         joined_q.push_back(j);
      end
      held_n = 0;
   endfunction

   function automatic void close_run(bit ovf);
      if (run_live && held_n > 0)
         held[0] = held[0] & ~trail_bit(run_dir);
      emit_group(ovf);
      run_live  = 1'b0;
      pend_join = 1'b0;
   endfunction

   function automatic void open_run(hold_char_type c, bit dir);
      run_live  = 1'b1;
      run_dir   = dir;
      pend_join = 1'b0;
      if (!c[BIT_SK]) begin
         c         = c & ~lead_bit(dir);
         pend_join = (c & trail_bit(dir)) != '0;
      end
      held[0] = c;
      held_n  = 1;
   endfunction

   function automatic void resolve_char(text_char_type t);
      hold_char_type c;
      int            base;
      c                       = '0;
      c[BIT_JR]               = t.jr;
      c[BIT_JL]               = t.jl;
      c[BIT_SK]               = t.sk;
      c[PROPS_LSB +: PROPS_W] = t.props;
      base                    = joined_q.size();
      if (run_live && t.rtl != run_dir)
         close_run(1'b0);
      if (!run_live) begin
         open_run(c, t.rtl);
      end else if (c[BIT_SK]) begin
         if (held_n >= SKIP_DEPTH + 1) begin
            close_run(1'b1);
            open_run(c, t.rtl);
         end else begin
            held[held_n] = c;
            held_n++;
         end
      end else begin
         if (!pend_join)
            c = c & ~lead_bit(run_dir);
         else if ((c & lead_bit(run_dir)) == '0)
            held[0] = held[0] & ~trail_bit(run_dir);
         else
            for (int k = 1; k < held_n; k++) held[k] = held[k] | MASK_BOTH;
         emit_group(1'b0);
         held[0]   = c;
         held_n    = 1;
         pend_join = (c & trail_bit(run_dir)) != '0;
      end
      if (t.eot)
         close_run(1'b0);
      if (joined_q.size() > base)
         joined_q[joined_q.size()-1].burst_end = 1'b1;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      mismatch_count++;
      $display("tb: result %0d: %s is %0h, expected %0h", rsp_count, what, got, want);
   endtask

   // driver: offer the head of text_q, predict on acceptance
   always @(posedge clock) begin : drive_chars
      bit offering;
      if (reset) begin
         req_valid <= 1'b0;
         held_n    = 0;
         pend_join = 1'b0;
         run_dir   = 1'b0;
         run_live  = 1'b0;
      end else begin
         offering = req_valid;
         if (req_valid && req_ready) begin
            resolve_char(text_q[0]);
            text_q.delete(0);
            offering = 1'b0;
         end
         if (!offering) begin
            if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_rtl         <= text_q[0].rtl;
               req_joins_right <= text_q[0].jr;
               req_joins_left  <= text_q[0].jl;
               req_skipped     <= text_q[0].sk;
               req_other_props <= text_q[0].props;
               req_end_of_text <= text_q[0].eot;
               req_valid       <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stalls plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (holdoff_trig != holdoff_seen) begin
            holdoff_seen = holdoff_trig;
            holdoff_left = HOLDOFF_CYCLES;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // monitor: compare each result with the oldest prediction
   always @(posedge clock) begin : check_results
      joined_char_type want;
      cycle_count++;
      if (!reset && rsp_valid && rsp_ready) begin
         if (joined_q.size() == 0) begin
            report_mismatch("unexpected result, props", int'(rsp_out_other_props), 0);
         end else begin
            want = joined_q.pop_front();
            if (rsp_out_joins_right !== want.chr[BIT_JR])
               report_mismatch("joins_right", int'(rsp_out_joins_right),
                               int'(want.chr[BIT_JR]));
            if (rsp_out_joins_left !== want.chr[BIT_JL])
               report_mismatch("joins_left", int'(rsp_out_joins_left),
                               int'(want.chr[BIT_JL]));
            if (rsp_out_skipped !== want.chr[BIT_SK])
               report_mismatch("skipped", int'(rsp_out_skipped), int'(want.chr[BIT_SK]));
            if (rsp_out_other_props !== want.chr[PROPS_LSB +: PROPS_W])
               report_mismatch("other_props", int'(rsp_out_other_props),
                               int'(want.chr[PROPS_LSB +: PROPS_W]));
            if (rsp_overflow !== want.ovf)
               report_mismatch("overflow", int'(rsp_overflow), int'(want.ovf));
            if (rsp_burst_last !== want.burst_end)
               report_mismatch("burst_last", int'(rsp_burst_last), int'(want.burst_end));
         end
         rsp_count++;
      end
   end

   task automatic push_char(bit rtl, bit jr, bit jl, bit sk, bit [7:0] props, bit eot);
      text_char_type t;
      t.rtl   = rtl;
      t.jr    = jr;
      t.jl    = jl;
      t.sk    = sk;
      t.props = props;
      t.eot   = eot;
      text_q.push_back(t);
   endtask

   // one joining character, then enough skipped ones to cut the run
   task automatic push_overflow_run(bit dir, bit eot_tail);
      push_char(dir, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0,
                8'($urandom_range(255)), 1'b0);
      for (int k = 0; k < SKIP_DEPTH + 1; k++)
         push_char(dir, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1,
                   8'($urandom_range(255)), (k == SKIP_DEPTH) ? eot_tail : 1'b0);
   endtask

   task automatic push_random_text(int n_items);
      int pushed;
      int kind;
      int len;
      int gap;
      bit dir;
      pushed = 0;
      dir    = 1'($urandom_range(1));
      while (pushed < n_items) begin
         kind = $urandom_range(99);
         if (kind < 10) begin
            push_char(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), 8'($urandom_range(255)),
                      1'($urandom_range(1)));
            pushed++;
         end else if (kind < 13) begin
            push_overflow_run(dir, 1'($urandom_range(1)));
            pushed += SKIP_DEPTH + 2;
         end else begin
            // one word: joining characters with a few skipped ones between
            if ($urandom_range(3) == 0)
               dir = ~dir;
            len = $urandom_range(6, 1);
            for (int w = 0; w < len; w++) begin
               push_char(dir, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0,
                         8'($urandom_range(255)), 1'b0);
               gap = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
               repeat (gap)
                  push_char(dir, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b1,
                            8'($urandom_range(255)), 1'b0);
               pushed += 1 + gap;
            end
            if ($urandom_range(9) < 3) begin
               push_char(dir, 1'($urandom_range(1)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), 8'($urandom_range(255)), 1'b1);
               pushed++;
            end
         end
      end
   endtask

   task automatic wait_drained();
      while (text_q.size() != 0 || joined_q.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // ltr: first char loses its preceding bit, join across a skipped char,
      // then no join back, then no join forward, end of text
      push_char(1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
      push_char(1'b0, 1'b1, 1'b1, 1'b1, 8'hFF, 1'b0);
      push_char(1'b0, 1'b1, 1'b1, 1'b0, 8'hA5, 1'b0);
      push_char(1'b0, 1'b0, 1'b0, 1'b0, 8'h5A, 1'b0);
      push_char(1'b0, 1'b1, 1'b1, 1'b0, 8'h3C, 1'b1);
      // rtl run of only skipped characters
      push_char(1'b1, 1'b1, 1'b1, 1'b1, 8'h0F, 1'b0);
      push_char(1'b1, 1'b1, 1'b0, 1'b1, 8'hF0, 1'b1);
      // leading skipped char, then direction changes flush the run
      push_char(1'b1, 1'b1, 1'b1, 1'b1, 8'h81, 1'b0);
      push_char(1'b1, 1'b1, 1'b1, 1'b0, 8'h7E, 1'b0);
      push_char(1'b0, 1'b1, 1'b0, 1'b0, 8'h01, 1'b0);
      push_char(1'b0, 1'b0, 1'b1, 1'b1, 8'h80, 1'b0);
      push_char(1'b1, 1'b0, 1'b0, 1'b1, 8'h55, 1'b1);
      // rtl joins, then the new char does not join back
      push_char(1'b1, 1'b1, 1'b1, 1'b0, 8'hFF, 1'b0);
      push_char(1'b1, 1'b1, 1'b1, 1'b0, 8'hAA, 1'b0);
      push_char(1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
      push_char(1'b1, 1'b1, 1'b1, 1'b0, 8'hFF, 1'b1);
      // full pending buffer, cut run closed by end of text
      push_overflow_run(1'b1, 1'b1);
      wait_drained();

      // hold the receiver off while the sender keeps offering
      holdoff_trig = holdoff_trig + 1;
      push_random_text(90);
      wait_drained();

      send_idle_pct = 81;
      push_random_text(75);
      wait_drained();

      send_idle_pct  = 0;
      recv_stall_pct = 81;
      push_random_text(75);
      wait_drained();

      send_idle_pct  = 34;
      recv_stall_pct = 34;
      push_random_text(75);
      push_char(1'b0, 1'b1, 1'b1, 1'b0, 8'hC3, 1'b1);
      wait_drained();

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && joined_q.size() == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb: errors");
      $finish;
   end

endmodule
